// ----- design/h4d_pkg.sv -----
// shared types and constants for the h4 deframer with in-band sleep detection
package h4d_pkg;

    localparam int MAX_FRAME_BYTES = 4096;
    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int LEN_W = 17;

    localparam logic [7:0] WAKE_BYTE  = 8'hfd;
    localparam logic [7:0] SLEEP_BYTE = 8'hfe;
    localparam logic [7:0] ACK_BYTE   = 8'hfc;
    localparam logic [7:0] ISO_LEN_RESERVED = 8'hc0;

    localparam logic [2:0] TYPE_NONE  = 3'd0;
    localparam logic [2:0] TYPE_CMD   = 3'd1;
    localparam logic [2:0] TYPE_ACL   = 3'd2;
    localparam logic [2:0] TYPE_SCO   = 3'd3;
    localparam logic [2:0] TYPE_EVENT = 3'd4;
    localparam logic [2:0] TYPE_ISO   = 3'd5;

    typedef enum logic [1:0] {
        CODE_NONE  = 2'd0,
        CODE_WAKE  = 2'd1,
        CODE_SLEEP = 2'd2,
        CODE_ACK   = 2'd3
    } ibs_code_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        frame_first;
        logic        frame_last;
        logic [2:0]  frame_type;
        logic        frame_error;
        ibs_code_t   ibs_code;
        logic        send_ack;
        logic        receiver_awake;
        logic [31:0] event_count;
    } result_t;

endpackage

// ----- design/h4d_in_stage.sv -----
// input register stage holding one received byte
module h4d_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       advance,
    output logic       held_valid,
    output logic [7:0] held_byte
);
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;
endmodule

// ----- design/h4d_core.sv -----
// frame and in-band sleep decode with frame state and counters
module h4d_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       c,
    output h4d_pkg::result_t res
);
    import h4d_pkg::*;

    logic [CNT_W-1:0] byte_count_reg,   byte_count_next;
    logic [CNT_W-1:0] frame_length_reg, frame_length_next;
    logic [2:0]       current_type_reg, current_type_next;
    logic [7:0]       length_low_reg,   length_low_next;
    logic             awake_reg,        awake_next;
    logic [31:0]      event_count_reg,  event_count_next;

    logic             idle;
    logic             is_ibs;
    logic             type_ok;
    logic [2:0]       ctype;
    logic [CNT_W-1:0] n;
    logic [LEN_W-1:0] x;
    logic [CNT_W-1:0] fl_eff;
    logic             bad;
    logic             last;

    assign idle    = (byte_count_reg == '0);
    assign is_ibs  = (c == WAKE_BYTE) || (c == SLEEP_BYTE) || (c == ACK_BYTE);
    assign type_ok = (c >= 8'd1) && (c <= 8'd5);
    assign ctype   = idle ? c[2:0] : current_type_reg;
    assign n       = byte_count_reg + CNT_W'(1);

    always_comb
    begin
        x               = '0;
        bad             = 1'b0;
        length_low_next = length_low_reg;
        if (byte_count_reg >= CNT_W'(MAX_FRAME_BYTES))
        begin
            bad = 1'b1;
        end
        else if (frame_length_reg == '0)
        begin
            if (ctype == TYPE_CMD || ctype == TYPE_SCO)
            begin
                if (n == CNT_W'(4))
                    x = LEN_W'(c) + LEN_W'(4);
            end
            else if (ctype == TYPE_EVENT)
            begin
                if (n == CNT_W'(3))
                    x = LEN_W'(c) + LEN_W'(3);
            end
            else
            begin
                if (n == CNT_W'(4))
                    length_low_next = c;
                else if (n == CNT_W'(5))
                begin
                    if (ctype == TYPE_ISO && (c & ISO_LEN_RESERVED) != 8'h00)
                        bad = 1'b1;
                    else
                        x = LEN_W'(5) + LEN_W'(length_low_reg) + LEN_W'({c, 8'h00});
                end
            end
            if (!bad && x != '0 && x > LEN_W'(MAX_FRAME_BYTES))
                bad = 1'b1;
        end
    end

    assign fl_eff = (frame_length_reg != '0) ? frame_length_reg
                  : ((x != '0) ? x[CNT_W-1:0] : '0);
    assign last   = !bad && (fl_eff != '0) && (n == fl_eff);

    always_comb
    begin
        res                = '0;
        res.out_byte       = c;
        res.ibs_code       = CODE_NONE;
        byte_count_next    = byte_count_reg;
        frame_length_next  = frame_length_reg;
        current_type_next  = current_type_reg;
        awake_next         = awake_reg;
        event_count_next   = event_count_reg;
        if (idle && is_ibs)
        begin
            if (c == WAKE_BYTE)
            begin
                res.ibs_code = CODE_WAKE;
                res.send_ack = 1'b1;
                awake_next   = 1'b1;
            end
            else if (c == SLEEP_BYTE)
            begin
                res.ibs_code = CODE_SLEEP;
                awake_next   = 1'b0;
            end
            else
            begin
                res.ibs_code = CODE_ACK;
            end
        end
        else if (idle && !type_ok)
        begin
            res.frame_error = 1'b1;
        end
        else
        begin
            res.byte_valid  = 1'b1;
            res.frame_first = idle;
            res.frame_type  = ctype;
            res.frame_last  = last;
            res.frame_error = bad;
            if (last && ctype == TYPE_EVENT)
                event_count_next = event_count_reg + 32'd1;
            if (last || bad)
            begin
                byte_count_next   = '0;
                frame_length_next = '0;
                current_type_next = TYPE_NONE;
            end
            else
            begin
                byte_count_next   = n;
                frame_length_next = fl_eff;
                current_type_next = ctype;
            end
        end
        res.receiver_awake = awake_next;
        res.event_count    = event_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= '0;
            frame_length_reg <= '0;
            current_type_reg <= TYPE_NONE;
            length_low_reg   <= '0;
            awake_reg        <= 1'b0;
            event_count_reg  <= '0;
        end
        else if (step)
        begin
            byte_count_reg   <= byte_count_next;
            frame_length_reg <= frame_length_next;
            current_type_reg <= current_type_next;
            length_low_reg   <= (last || bad || (idle && (is_ibs || !type_ok)))
                                ? 8'h00 : length_low_next;
            awake_reg        <= awake_next;
            event_count_reg  <= event_count_next;
        end
    end
endmodule

// ----- design/h4d_out_stage.sv -----
// result register stage toward the downstream consumer
module h4d_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  h4d_pkg::result_t res_in,
    output logic             space,
    output logic             out_valid,
    input  logic             out_ready,
    output h4d_pkg::result_t res_out
);
    import h4d_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign space      = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;
endmodule

// ----- design/h4_hci_deframer_ibs.sv -----
// top level of the h4 hci receive deframer with in-band sleep detection
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------
//  in      | input     | in_valid / in_ready   | rx_byte
//  out     | output    | out_valid / out_ready | out_byte .. event_count
//
// one beat in, one beat out; a beat crosses the input register and then the result register
// a new beat is taken every cycle while the result register drains
// frame state and counters advance as a beat moves into the result register
// reset clears frame state, awake flag and event counter
// a stalled output holds its beat and backs up into the input register
module h4_hci_deframer_ibs (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        frame_first,
    output logic        frame_last,
    output logic [2:0]  frame_type,
    output logic        frame_error,
    output logic [1:0]  ibs_code,
    output logic        send_ack,
    output logic        receiver_awake,
    output logic [31:0] event_count
);
    import h4d_pkg::*;

    logic       held_valid;
    logic [7:0] held_byte;
    logic       space;
    logic       advance;
    result_t    res_core;
    result_t    res_out;

    assign advance = held_valid && space;

    h4d_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    h4d_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .c     (held_byte),
        .res   (res_core)
    );

    h4d_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .res_in    (res_core),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_out   (res_out)
    );

    assign out_byte       = res_out.out_byte;
    assign byte_valid     = res_out.byte_valid;
    assign frame_first    = res_out.frame_first;
    assign frame_last     = res_out.frame_last;
    assign frame_type     = res_out.frame_type;
    assign frame_error    = res_out.frame_error;
    assign ibs_code       = res_out.ibs_code;
    assign send_ack       = res_out.send_ack;
    assign receiver_awake = res_out.receiver_awake;
    assign event_count    = res_out.event_count;

`ifndef SYNTHESIS
    a_first_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_first |-> byte_valid && frame_type != TYPE_NONE)
        else $error("frame start outside a frame");

    a_last_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_last |-> byte_valid && !frame_error)
        else $error("frame end with error");

    a_ack_awake: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && send_ack |-> receiver_awake && ibs_code == CODE_WAKE)
        else $error("acknowledge without wake");

    a_ibs_not_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ibs_code != CODE_NONE |-> !byte_valid && !frame_error)
        else $error("sleep byte marked as frame byte");
`endif
endmodule

// ----- tb/h4_hci_deframer_ibs_tb.sv -----
// self-checking testbench for the h4 hci deframer with in-band sleep detection
module h4_hci_deframer_ibs_tb;
    import h4d_pkg::*;

    localparam int IDLE_PCT     = 27;
    localparam int RANDOM_BYTES = 1250;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 120;

    class deframe_scoreboard;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] flen;
        logic [2:0]       cur_type;
        logic [7:0]       len_low;
        logic             awake;
        logic [31:0]      events;
        result_t          expected_q[$];
        int               taken;
        int               beats;
        int               mismatches;

        function new();
            count = '0;
            flen = '0;
            cur_type = TYPE_NONE;
            len_low = '0;
            awake = 1'b0;
            events = '0;
            taken = 0;
            beats = 0;
            mismatches = 0;
        endfunction

        function void go_idle();
            count = '0;
            flen = '0;
            cur_type = TYPE_NONE;
            len_low = '0;
        endfunction

        function result_t deframe_byte(logic [7:0] c);
            result_t          r;
            logic [LEN_W-1:0] x;
            logic [CNT_W-1:0] n;
            bit               bad;
            r = '0;
            r.out_byte = c;
            r.ibs_code = CODE_NONE;
            x = '0;
            bad = 1'b0;
            if (count == 0 && (c == WAKE_BYTE || c == SLEEP_BYTE || c == ACK_BYTE))
            begin
                if (c == WAKE_BYTE)
                begin
                    r.ibs_code = CODE_WAKE;
                    r.send_ack = 1'b1;
                    awake = 1'b1;
                end
                else if (c == SLEEP_BYTE)
                begin
                    r.ibs_code = CODE_SLEEP;
                    awake = 1'b0;
                end
                else
                begin
                    r.ibs_code = CODE_ACK;
                end
            end
            else if (count == 0 && (c < TYPE_CMD || c > TYPE_ISO))
            begin
                r.frame_error = 1'b1;
            end
            else
            begin
                if (count == 0)
                begin
                    cur_type = c[2:0];
                    r.frame_first = 1'b1;
                end
                r.byte_valid = 1'b1;
                r.frame_type = cur_type;
                if (count >= MAX_FRAME_BYTES)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    n = count + 1'b1;
                    count = n;
                    if (flen == 0)
                    begin
                        if (cur_type == TYPE_CMD || cur_type == TYPE_SCO)
                        begin
                            if (n == 4)
                                x = LEN_W'(4) + LEN_W'(c);
                        end
                        else if (cur_type == TYPE_EVENT)
                        begin
                            if (n == 3)
                                x = LEN_W'(3) + LEN_W'(c);
                        end
                        else if (n == 4)
                        begin
                            len_low = c;
                        end
                        else if (n == 5)
                        begin
                            if (cur_type == TYPE_ISO && (c & ISO_LEN_RESERVED) != 0)
                                bad = 1'b1;
                            else
                                x = LEN_W'(5) + LEN_W'(len_low) + LEN_W'({c, 8'h00});
                        end
                        if (!bad && x != 0)
                        begin
                            if (x > MAX_FRAME_BYTES)
                                bad = 1'b1;
                            else
                                flen = x[CNT_W-1:0];
                        end
                    end
                    if (!bad && flen != 0 && count == flen)
                    begin
                        r.frame_last = 1'b1;
                        if (cur_type == TYPE_EVENT)
                            events = events + 32'd1;
                        go_idle();
                    end
                end
                if (bad)
                begin
                    r.frame_error = 1'b1;
                    go_idle();
                end
            end
            r.receiver_awake = awake;
            r.event_count = events;
            return r;
        endfunction

        function void note_byte(logic [7:0] c);
            taken++;
            expected_q.push_back(deframe_byte(c));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
            if (exp !== act)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch on beat %0d, %s: expected %0h, got %0h",
                             beats, name, exp, act);
            end
        endfunction

        function void check_beat(result_t act);
            result_t exp;
            beats++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat %0d: out_byte %0h", beats, act.out_byte);
                return;
            end
            exp = expected_q.pop_front();
            compare_field("out_byte", 32'(exp.out_byte), 32'(act.out_byte));
            compare_field("byte_valid", 32'(exp.byte_valid), 32'(act.byte_valid));
            compare_field("frame_first", 32'(exp.frame_first), 32'(act.frame_first));
            compare_field("frame_last", 32'(exp.frame_last), 32'(act.frame_last));
            compare_field("frame_type", 32'(exp.frame_type), 32'(act.frame_type));
            compare_field("frame_error", 32'(exp.frame_error), 32'(act.frame_error));
            compare_field("ibs_code", 32'(exp.ibs_code), 32'(act.ibs_code));
            compare_field("send_ack", 32'(exp.send_ack), 32'(act.send_ack));
            compare_field("receiver_awake", 32'(exp.receiver_awake),
                          32'(act.receiver_awake));
            compare_field("event_count", exp.event_count, act.event_count);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        frame_first;
    logic        frame_last;
    logic [2:0]  frame_type;
    logic        frame_error;
    logic [1:0]  ibs_code;
    logic        send_ack;
    logic        receiver_awake;
    logic [31:0] event_count;

    deframe_scoreboard sb = new();
    bit no_idle = 1'b0;
    int cycles = 0;

    h4_hci_deframer_ibs u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_byte(out_byte),
        .byte_valid(byte_valid),
        .frame_first(frame_first),
        .frame_last(frame_last),
        .frame_type(frame_type),
        .frame_error(frame_error),
        .ibs_code(ibs_code),
        .send_ack(send_ack),
        .receiver_awake(receiver_awake),
        .event_count(event_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic send_byte(logic [7:0] b);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_byte(b);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic send_frame(logic [2:0] t, int plen);
        send_byte({5'd0, t});
        if (t == TYPE_EVENT)
        begin
            send_byte(8'($urandom_range(255)));
            send_byte(plen[7:0]);
        end
        else
        begin
            send_byte(8'($urandom_range(255)));
            send_byte(8'($urandom_range(255)));
            send_byte(plen[7:0]);
            if (t == TYPE_ACL || t == TYPE_ISO)
                send_byte(plen[15:8]);
        end
        repeat (plen)
            send_byte(8'($urandom_range(255)));
    endtask

    task automatic send_noise();
        int pick;
        pick = $urandom_range(99);
        if (pick < 20)
            send_byte(WAKE_BYTE);
        else if (pick < 40)
            send_byte(SLEEP_BYTE);
        else if (pick < 60)
            send_byte(ACK_BYTE);
        else if (pick < 70)
            send_byte(8'h00);
        else if (pick < 80)
            send_byte(8'hff);
        else if (pick < 90)
            send_byte(8'($urandom_range(6, 8'hfb)));
        else
            send_byte(8'($urandom_range(255)));
    endtask

    // headers that abort the frame
    task automatic send_broken();
        int pick;
        pick = $urandom_range(3);
        send_byte(pick[1] ? {5'd0, TYPE_ISO} : {5'd0, TYPE_ACL});
        send_byte(8'($urandom_range(255)));
        send_byte(8'($urandom_range(255)));
        case (pick)
            0:
            begin
                send_byte(8'($urandom_range(255)));
                send_byte(8'($urandom_range(16, 255)));
            end
            1:
            begin
                send_byte(8'($urandom_range(8'hfc, 8'hff)));
                send_byte(8'h0f);
            end
            2:
            begin
                send_byte(8'($urandom_range(255)));
                send_byte(8'($urandom_range(64, 255)));
            end
            default:
            begin
                send_byte(8'($urandom_range(255)));
                send_byte(8'($urandom_range(16, 63)));
            end
        endcase
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(8);
        else if (r < 95)
            return $urandom_range(9, 40);
        return $urandom_range(41, 255);
    endfunction

    initial
    begin : receive
        result_t seen;
        int      hold_left;
        bit      held;
        hold_left = 0;
        held = 1'b0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                seen.out_byte = out_byte;
                seen.byte_valid = byte_valid;
                seen.frame_first = frame_first;
                seen.frame_last = frame_last;
                seen.frame_type = frame_type;
                seen.frame_error = frame_error;
                seen.ibs_code = ibs_code_t'(ibs_code);
                seen.send_ack = send_ack;
                seen.receiver_awake = receiver_awake;
                seen.event_count = event_count;
                sb.check_beat(seen);
            end
            if (!held && sb.taken >= 400)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (no_idle)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin : watchdog
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int  pick;
        int  target;
        bit  paused;
        bit  big_done;
        paused = 1'b0;
        big_done = 1'b0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        rx_byte <= 8'h00;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(WAKE_BYTE);
        send_byte(SLEEP_BYTE);
        send_byte(ACK_BYTE);
        send_byte(8'h00);
        send_byte(8'hff);
        // in-band values inside a frame are plain bytes
        send_byte(8'(TYPE_CMD));
        send_byte(WAKE_BYTE);
        send_byte(SLEEP_BYTE);
        send_byte(8'h00);
        send_byte(8'(TYPE_EVENT));
        send_byte(ACK_BYTE);
        send_byte(8'h01);
        send_byte(8'hff);
        // acl header giving one byte over the maximum
        send_byte(8'(TYPE_ACL));
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hfc);
        send_byte(8'h0f);
        // iso with reserved length bits
        send_byte(8'(TYPE_ISO));
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h40);
        wait_drained();

        target = sb.taken + RANDOM_BYTES;
        while (sb.taken < target)
        begin
            if (!paused && sb.taken >= 700)
            begin
                paused = 1'b1;
                wait_drained();
            end
            no_idle = (sb.taken >= 900 && sb.taken < 1100);
            if (!big_done && sb.taken >= 500)
            begin
                big_done = 1'b1;
                send_frame(TYPE_ACL, 300);
            end
            pick = $urandom_range(99);
            if (pick < 75)
                send_frame(3'($urandom_range(TYPE_CMD, TYPE_ISO)), pick_len());
            else if (pick < 90)
                send_noise();
            else
                send_broken();
        end
        no_idle = 1'b0;
        wait_drained();
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
